[design/mcjp_pkg.sv]
// Shared types, constants and selection function for the minimum-cost jump path block.
// Depends on nothing. Used by min_cost_jump_path_dp.
package mcjp_pkg;

    localparam int MAX_INDEX = 63;
    localparam int DEPTH     = MAX_INDEX + 1;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WGT_W     = 10;
    localparam int COST_W    = 16;
    localparam int LEN_W     = 7;
    localparam int WIN       = 3;                 // stones a jump may span
    localparam int SLOT_W    = 2;
    localparam int IN_DW     = 16;                // stone_weight padded to bytes
    localparam int OUT_DW    = 24;                // total_cost, stop_index, padding

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PICK,
        ST_TRACE,
        ST_EMIT
    } t_state;

    typedef logic [WIN-1:0][COST_W-1:0] t_cost_win;
    typedef logic [WIN-1:0][LEN_W-1:0]  t_len_win;

    // Pick the best valid slot: least cost, then greater length, then lower slot.
    function automatic logic [SLOT_W-1:0] pick_best(
        input t_cost_win     cost,
        input t_len_win      len,
        input logic [WIN-1:0] valid
    );
        logic [SLOT_W-1:0] best;
        logic              found;
        best  = '0;
        found = 1'b0;
        for (int k = 0; k < WIN; k++) begin
            if (valid[k]) begin
                if (!found) begin
                    best  = SLOT_W'(k);
                    found = 1'b1;
                end else if (cost[k] < cost[best] ||
                             (cost[k] == cost[best] && len[k] > len[best])) begin
                    best = SLOT_W'(k);
                end
            end
        end
        return best;
    endfunction

endpackage

[design/min_cost_jump_path_dp.sv]
// Minimum-cost jump path: stone intake, predecessor store, traceback and path output.
// Timing: one stone per cycle while loading. After the final stone the block picks the winner
// and walks the predecessor memory (one read per cycle, registered read) into trail memory,
// then replays the results from the trail read port with one read in flight at a time.
// Input is held off from the final stone until the last result sits in the output register.
// Reset (synchronous, active low) clears the stone count and all control; memories keep data.
module min_cost_jump_path_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [mcjp_pkg::IN_DW-1:0]  i_s_tdata,   // [9:0] stone_weight, [15:10] zero
    input  logic                        i_s_tlast,   // final_stone
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [mcjp_pkg::OUT_DW-1:0] o_m_tdata,   // [15:0] total_cost, [21:16] stop_index
    output logic                        o_m_tlast    // path_end
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    mcjp_pkg::t_state r_state, n_state;

    logic [mcjp_pkg::CNT_W-1:0]  r_cnt;           // stones taken in this sequence
    logic [mcjp_pkg::IDX_W-1:0]  r_last;          // index of the final stone
    logic [mcjp_pkg::COST_W-1:0] r_cost0;         // cost of stone 0
    mcjp_pkg::t_cost_win         r_wc;            // costs of the three latest stones
    mcjp_pkg::t_len_win          r_wl;            // path lengths of the same
    logic [mcjp_pkg::COST_W-1:0] r_win_cost;      // total cost of the chosen path

    // Predecessor memory, one entry per stone, registered read.
    logic [mcjp_pkg::IDX_W-1:0]  r_pred_mem [mcjp_pkg::DEPTH];
    logic [mcjp_pkg::IDX_W-1:0]  r_pred_rd;

    // Trail memory: the path as walked backwards, replayed in reverse.
    logic [mcjp_pkg::IDX_W-1:0]  r_trail_mem [mcjp_pkg::DEPTH];
    logic [mcjp_pkg::IDX_W-1:0]  r_trail_rd;
    logic [mcjp_pkg::CNT_W-1:0]  r_sp;            // entries held in the trail memory
    logic                        r_pend;          // trail read in flight
    logic                        r_pend_last;     // ... and it is the final result

    // Output register.
    logic                        r_out_valid;
    logic [mcjp_pkg::COST_W-1:0] r_out_cost;
    logic [mcjp_pkg::IDX_W-1:0]  r_out_idx;
    logic                        r_out_last;

    // ------------------------------------------------------------------
    // Stone intake: one compare over the window and one add per stone
    // ------------------------------------------------------------------
    logic                        s_acc;
    logic                        in_range;
    logic [mcjp_pkg::IDX_W-1:0]  idx;
    logic [mcjp_pkg::WGT_W-1:0]  weight;
    logic [mcjp_pkg::SLOT_W-1:0] step_slot;
    logic [mcjp_pkg::COST_W-1:0] base_cost;
    logic [mcjp_pkg::COST_W:0]   sum;
    logic [mcjp_pkg::COST_W-1:0] new_cost;
    logic [mcjp_pkg::LEN_W-1:0]  new_len;
    logic [mcjp_pkg::IDX_W-1:0]  new_pred;
    logic [mcjp_pkg::IDX_W-1:0]  new_last;

    assign o_s_tready = (r_state == mcjp_pkg::ST_LOAD);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign weight     = i_s_tdata[mcjp_pkg::WGT_W-1:0];
    assign in_range   = (r_cnt <= mcjp_pkg::CNT_W'(mcjp_pkg::MAX_INDEX));
    assign idx        = r_cnt[mcjp_pkg::IDX_W-1:0];
    assign step_slot  = mcjp_pkg::pick_best(r_wc, r_wl, '1);

    always_comb begin
        new_last = in_range ? idx : mcjp_pkg::IDX_W'(mcjp_pkg::MAX_INDEX);
        if (r_cnt == '0) begin
            base_cost = '0;
            new_len   = mcjp_pkg::LEN_W'(1);
            new_pred  = '0;
        end else if (r_cnt <= mcjp_pkg::CNT_W'(mcjp_pkg::WIN)) begin
            // the first few stones are always reached from stone 0
            base_cost = r_cost0;
            new_len   = mcjp_pkg::LEN_W'(2);
            new_pred  = '0;
        end else begin
            base_cost = r_wc[step_slot];
            new_len   = r_wl[step_slot] + mcjp_pkg::LEN_W'(1);
            new_pred  = idx - mcjp_pkg::IDX_W'(mcjp_pkg::WIN)
                        + mcjp_pkg::IDX_W'(step_slot);
        end
        sum      = {1'b0, base_cost} + (mcjp_pkg::COST_W + 1)'(weight);
        new_cost = sum[mcjp_pkg::COST_W] ? '1 : sum[mcjp_pkg::COST_W-1:0];
    end

    // ------------------------------------------------------------------
    // Final compare over the last three stones (fewer on a short run)
    // ------------------------------------------------------------------
    logic [mcjp_pkg::WIN-1:0]    fin_valid;
    logic [mcjp_pkg::SLOT_W-1:0] fin_slot;
    logic [mcjp_pkg::IDX_W-1:0]  win_idx;

    always_comb begin
        if (r_last == '0) begin
            fin_valid = 3'b100;
        end else if (r_last == mcjp_pkg::IDX_W'(1)) begin
            fin_valid = 3'b110;
        end else begin
            fin_valid = 3'b111;
        end
    end

    assign fin_slot = mcjp_pkg::pick_best(r_wc, r_wl, fin_valid);
    // window slot k holds stone r_last - 2 + k
    assign win_idx  = r_last - mcjp_pkg::IDX_W'(2) + mcjp_pkg::IDX_W'(fin_slot);

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic                       pred_we;
    logic [mcjp_pkg::IDX_W-1:0] pred_ra;
    logic                       trail_we;
    logic [mcjp_pkg::IDX_W-1:0] trail_wd;
    logic                       emit_issue;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcjp_pkg::ST_LOAD: begin
                if (s_acc && i_s_tlast) begin
                    n_state = mcjp_pkg::ST_PICK;
                end
            end
            mcjp_pkg::ST_PICK: begin
                n_state = (win_idx == '0) ? mcjp_pkg::ST_EMIT : mcjp_pkg::ST_TRACE;
            end
            mcjp_pkg::ST_TRACE: begin
                if (r_pred_rd == '0) begin
                    n_state = mcjp_pkg::ST_EMIT;
                end
            end
            mcjp_pkg::ST_EMIT: begin
                if (r_pend && r_pend_last) begin
                    n_state = mcjp_pkg::ST_LOAD;
                end
            end
            default: n_state = mcjp_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        pred_we    = s_acc && in_range;
        // walk: the winner first, then each predecessor as it comes back
        pred_ra    = (r_state == mcjp_pkg::ST_PICK) ? win_idx : r_pred_rd;
        trail_we   = (r_state == mcjp_pkg::ST_PICK) || (r_state == mcjp_pkg::ST_TRACE);
        trail_wd   = (r_state == mcjp_pkg::ST_PICK) ? win_idx : r_pred_rd;
        emit_issue = (r_state == mcjp_pkg::ST_EMIT) && (r_sp != '0) && !r_pend
                     && (!r_out_valid || i_m_tready);
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (pred_we) begin
            r_pred_mem[idx] <= new_pred;
        end
        r_pred_rd <= r_pred_mem[pred_ra];
    end

    always_ff @(posedge i_clk) begin
        if (trail_we) begin
            r_trail_mem[r_sp[mcjp_pkg::IDX_W-1:0]] <= trail_wd;
        end
        r_trail_rd <= r_trail_mem[r_sp[mcjp_pkg::IDX_W-1:0] - mcjp_pkg::IDX_W'(1)];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcjp_pkg::ST_LOAD;
            r_cnt       <= '0;
            r_sp        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // stone count: hold at the top once past the last index
            if (s_acc) begin
                if (i_s_tlast) begin
                    r_cnt <= '0;
                end else if (in_range) begin
                    r_cnt <= r_cnt + mcjp_pkg::CNT_W'(1);
                end
            end

            // trail pointer: push while walking, pop while replaying
            if (r_state == mcjp_pkg::ST_PICK) begin
                r_sp <= mcjp_pkg::CNT_W'(1);
            end else if (r_state == mcjp_pkg::ST_TRACE) begin
                r_sp <= r_sp + mcjp_pkg::CNT_W'(1);
            end else if (emit_issue) begin
                r_sp <= r_sp - mcjp_pkg::CNT_W'(1);
            end

            r_pend <= emit_issue;

            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_last <= new_last;
            if (in_range) begin
                r_wc <= {new_cost, r_wc[2], r_wc[1]};
                r_wl <= {new_len,  r_wl[2], r_wl[1]};
                if (r_cnt == '0) begin
                    r_cost0 <= new_cost;
                end
            end
        end
        if (r_state == mcjp_pkg::ST_PICK) begin
            r_win_cost <= r_wc[fin_slot];
        end
        if (emit_issue) begin
            r_pend_last <= (r_sp == mcjp_pkg::CNT_W'(1));
        end
        if (r_pend) begin
            r_out_cost <= r_win_cost;
            r_out_idx  <= r_trail_rd;
            r_out_last <= r_pend_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_idx, r_out_cost};
    assign o_m_tlast  = r_out_last;

endmodule
